[src/slex_pkg.sv]
`default_nettype none
package slex_pkg;
    localparam int PosWidthDefault = 16;
    localparam int MaxResults = 4;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_VAR, M_MAP, M_INT, M_STR, M_ESC, M_HEX, M_OCT,
        M_OP, M_LCOM, M_BCOM, M_BSTAR
    } t_mode;

    localparam logic [4:0] T_INT = 5'd0;
    localparam logic [4:0] T_STR = 5'd1;
    localparam logic [4:0] T_IDENT = 5'd2;
    localparam logic [4:0] T_VAR = 5'd3;
    localparam logic [4:0] T_MAP = 5'd4;
    localparam logic [4:0] T_OP = 5'd6;
    localparam logic [4:0] T_END = 5'd16;
    localparam logic [4:0] T_UNKNOWN = 5'd17;
    localparam logic [4:0] OP_NONE = 5'd31;

    function automatic logic f_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic f_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [4:0] f_hex(input logic [7:0] b);
        if (f_digit(b)) return {1'b0, b[3:0]};
        if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
            return {1'b0, b[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic logic [4:0] f_single_op(input logic [7:0] c);
        case (c)
            "=": return 5'd0;
            "!": return 5'd21;
            "+": return 5'd11;
            "-": return 5'd14;
            "&": return 5'd18;
            "|": return 5'd19;
            "<": return 5'd7;
            ">": return 5'd8;
            "%": return 5'd17;
            "*": return 5'd15;
            "~": return 5'd22;
            "^": return 5'd20;
            default: return 5'd16;
        endcase
    endfunction

    function automatic logic [4:0] f_pair_op(input logic [7:0] c, input logic [7:0] b);
        if (c == "=" && b == "=") return 5'd1;
        if (c == "!" && b == "=") return 5'd2;
        if (c == "+" && b == "+") return 5'd12;
        if (c == "-" && b == "-") return 5'd13;
        if (c == "&" && b == "&") return 5'd9;
        if (c == "|" && b == "|") return 5'd10;
        if (c == "<" && b == "=") return 5'd3;
        if (c == "<" && b == "<") return 5'd5;
        if (c == ">" && b == "=") return 5'd4;
        if (c == ">" && b == ">") return 5'd6;
        return OP_NONE;
    endfunction

    function automatic logic [4:0] f_punct(input logic [7:0] b);
        case (b)
            ",": return 5'd5;
            "?": return 5'd7;
            ":": return 5'd8;
            ";": return 5'd9;
            "{": return 5'd10;
            "}": return 5'd11;
            "[": return 5'd12;
            "]": return 5'd13;
            "(": return 5'd14;
            ")": return 5'd15;
            default: return T_UNKNOWN;
        endcase
    endfunction

    function automatic logic [4:0] f_word_type(input t_mode m);
        case (m)
            M_VAR: return T_VAR;
            M_MAP: return T_MAP;
            M_INT: return T_INT;
            default: return T_IDENT;
        endcase
    endfunction

    // one result without position; position is attached by the top level
    typedef struct packed {
        logic       is_end;
        logic [4:0] ttype;
        logic [4:0] op;
        logic [7:0] data;
        logic       at_cur;  // position is current line/column, not token start
    } t_res;

    typedef struct packed {
        logic [2:0] count;
        t_res [MaxResults-1:0] res;
    } t_res_set;
endpackage
`default_nettype wire

[src/slex_if.sv]
`default_nettype none
interface slex_if #(parameter int Width = 8);
    logic             valid;
    logic             ready;
    logic [Width-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/slex_core.sv]
`default_nettype none
module slex_core
    import slex_pkg::*;
(
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eoi,
    input  wire t_mode      i_mode,
    input  wire logic [7:0] i_pend,
    input  wire logic [7:0] i_esc_val,
    input  wire logic [1:0] i_esc_dig,
    output t_mode           o_mode,
    output logic [7:0]      o_pend,
    output logic [7:0]      o_esc_val,
    output logic [1:0]      o_esc_dig,
    output logic            o_tok_start,
    output t_res_set        o_set
);
    t_res_set   s;
    t_mode      m;
    logic [7:0] b;
    logic       done;
    logic [4:0] h;
    logic [4:0] op;
    logic [7:0] ev;
    logic [1:0] ed;

    always_comb begin
        s = '0;
        m = i_mode;
        o_pend = i_pend;
        ev = i_esc_val;
        ed = i_esc_dig;
        o_tok_start = 1'b0;
        b = i_byte;
        done = 1'b0;
        h = f_hex(b);
        op = f_pair_op(i_pend, b);
        if (i_eoi) begin
            case (i_mode)
                M_IDENT, M_VAR, M_MAP, M_INT: begin
                    s.res[s.count[1:0]] = '{1'b1, f_word_type(i_mode), 5'd0, 8'd0, 1'b0};
                    s.count = s.count + 3'd1;
                end
                M_OP: begin
                    s.res[s.count[1:0]] = '{1'b1, T_OP, f_single_op(i_pend), 8'd0, 1'b0};
                    s.count = s.count + 3'd1;
                end
                M_HEX, M_OCT: begin
                    s.res[0] = '{1'b0, T_STR, 5'd0, i_esc_val, 1'b0};
                    s.res[1] = '{1'b1, T_STR, 5'd0, 8'd0, 1'b0};
                    s.count = 3'd2;
                end
                M_STR, M_ESC: begin
                    s.res[0] = '{1'b1, T_STR, 5'd0, 8'd0, 1'b0};
                    s.count = 3'd1;
                end
                default: ;
            endcase
            s.res[s.count[1:0]] = '{1'b1, T_END, 5'd0, 8'd0, 1'b1};
            s.count = s.count + 3'd1;
            m = M_IDLE;
            o_pend = '0;
            ev = '0;
            ed = '0;
        end else begin
            // first pass: modes that may hand the byte back
            case (m)
                M_IDENT, M_VAR, M_MAP, M_INT: begin
                    if ((m == M_INT) ? f_digit(b) : (f_alpha(b) || f_digit(b))) begin
                        s.res[0] = '{1'b0, f_word_type(m), 5'd0, b, 1'b0};
                        s.count = 3'd1;
                        done = 1'b1;
                    end else begin
                        s.res[0] = '{1'b1, f_word_type(m), 5'd0, 8'd0, 1'b0};
                        s.count = 3'd1;
                        m = M_IDLE;
                    end
                end
                M_OP: begin
                    m = M_IDLE;
                    if (i_pend == "/" && (b == "/" || b == "*")) begin
                        m = (b == "/") ? M_LCOM : M_BCOM;
                        done = 1'b1;
                    end else if (op != OP_NONE) begin
                        s.res[0] = '{1'b1, T_OP, op, 8'd0, 1'b0};
                        s.count = 3'd1;
                        done = 1'b1;
                    end else begin
                        s.res[0] = '{1'b1, T_OP, f_single_op(i_pend), 8'd0, 1'b0};
                        s.count = 3'd1;
                    end
                end
                M_HEX: begin
                    if (!h[4]) begin
                        ev = {i_esc_val[3:0], h[3:0]};
                        ed = i_esc_dig + 2'd1;
                        if (ed >= 2'd2) begin
                            s.res[0] = '{1'b0, T_STR, 5'd0, ev, 1'b0};
                            s.count = 3'd1;
                            m = M_STR;
                        end
                        done = 1'b1;
                    end else begin
                        s.res[0] = '{1'b0, T_STR, 5'd0, i_esc_val, 1'b0};
                        s.count = 3'd1;
                        m = M_STR;
                    end
                end
                M_OCT: begin
                    if (b >= "0" && b <= "7") begin
                        ev = {i_esc_val[4:0], b[2:0]};
                        ed = i_esc_dig + 2'd1;
                        if (ed == 2'd3 || ed == 2'd0) begin
                            s.res[0] = '{1'b0, T_STR, 5'd0, ev, 1'b0};
                            s.count = 3'd1;
                            m = M_STR;
                        end
                        done = 1'b1;
                    end else begin
                        s.res[0] = '{1'b0, T_STR, 5'd0, i_esc_val, 1'b0};
                        s.count = 3'd1;
                        m = M_STR;
                    end
                end
                default: ;
            endcase
            // second pass: modes that always take the byte
            if (!done) begin
                case (m)
                    M_STR: begin
                        if (b == "\"") begin
                            s.res[s.count[1:0]] = '{1'b1, T_STR, 5'd0, 8'd0, 1'b0};
                            s.count = s.count + 3'd1;
                            m = M_IDLE;
                        end else if (b == "\\") begin
                            m = M_ESC;
                        end else begin
                            s.res[s.count[1:0]] = '{1'b0, T_STR, 5'd0, b, 1'b0};
                            s.count = s.count + 3'd1;
                        end
                    end
                    M_ESC: begin
                        m = M_STR;
                        case (b)
                            "a", "b", "t", "n", "v", "f", "r", "e",
                            "\"", "'", "?", "\\": begin
                                s.res[0] = '{1'b0, T_STR, 5'd0,
                                    (b == "a") ? 8'd7 : (b == "b") ? 8'd8 :
                                    (b == "t") ? 8'd9 : (b == "n") ? 8'd10 :
                                    (b == "v") ? 8'd11 : (b == "f") ? 8'd12 :
                                    (b == "r") ? 8'd13 : (b == "e") ? 8'd27 : b,
                                    1'b0};
                                s.count = 3'd1;
                            end
                            8'h0a: ;
                            "x": begin
                                ev = '0;
                                ed = '0;
                                m = M_HEX;
                            end
                            default: begin
                                if (b >= "0" && b <= "7") begin
                                    ev = {5'd0, b[2:0]};
                                    ed = 2'd1;
                                    m = M_OCT;
                                end else begin
                                    s.res[0] = '{1'b0, T_STR, 5'd0, "\\", 1'b0};
                                    s.res[1] = '{1'b0, T_STR, 5'd0, b, 1'b0};
                                    s.count = 3'd2;
                                end
                            end
                        endcase
                    end
                    M_LCOM: if (b == 8'h0a) m = M_IDLE;
                    M_BCOM: if (b == "*") m = M_BSTAR;
                    M_BSTAR: begin
                        if (b == "/") m = M_IDLE;
                        else if (b != "*") m = M_BCOM;
                    end
                    default: begin
                        m = M_IDLE;
                        if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a) begin
                        end else if (b == "#") begin
                            m = M_LCOM;
                        end else begin
                            o_tok_start = 1'b1;
                            if (b == "\"") m = M_STR;
                            else if (f_alpha(b)) begin
                                m = M_IDENT;
                                s.res[s.count[1:0]] = '{1'b0, T_IDENT, 5'd0, b, 1'b1};
                                s.count = s.count + 3'd1;
                            end else if (f_digit(b)) begin
                                m = M_INT;
                                s.res[s.count[1:0]] = '{1'b0, T_INT, 5'd0, b, 1'b1};
                                s.count = s.count + 3'd1;
                            end else if (b == "$") m = M_VAR;
                            else if (b == "@") m = M_MAP;
                            else if (b == "=" || b == "!" || b == "+" || b == "-" ||
                                     b == "&" || b == "|" || b == "<" || b == ">" ||
                                     b == "/") begin
                                o_pend = b;
                                m = M_OP;
                            end else if (b == "%" || b == "*" || b == "~" || b == "^") begin
                                s.res[s.count[1:0]] = '{1'b1, T_OP, f_single_op(b), 8'd0, 1'b1};
                                s.count = s.count + 3'd1;
                            end else begin
                                s.res[s.count[1:0]] = '{1'b0, f_punct(b), 5'd0, b, 1'b1};
                                s.res[s.count[1:0] + 2'd1] = '{1'b1, f_punct(b), 5'd0, 8'd0, 1'b1};
                                s.count = s.count + 3'd2;
                            end
                        end
                    end
                endcase
            end
        end
        o_mode = m;
        o_esc_val = ev;
        o_esc_dig = ed;
        o_set = s;
    end
endmodule
`default_nettype wire

[src/script_lexer.sv]
`default_nettype none
// channel | dir | payload
// in      | in  | {end_of_input, char_byte}
// out     | out | {is_token_end, token_type, operator_code, content_byte,
//         |     |  tok_line, tok_col, last}
// one byte per cycle when the buffer is free: lexer state and the up to three results of an
// item are computed in one pass and parked in a result buffer, drained one per cycle while
// the output is ready; an item's results occupy the buffer until the last one leaves;
// a new item is taken when the buffer is empty or in the cycle the last buffered result leaves
// synchronous active-low reset returns lexer state and positions to start
module script_lexer
    import slex_pkg::*;
#(
    parameter int POSITION_WIDTH = PosWidthDefault
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    slex_if.sink     i_in,
    slex_if.source   o_out
);
    localparam logic [POSITION_WIDTH-1:0] PosOne = POSITION_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

    // lexer state
    t_mode                    r_mode;
    logic [7:0]               r_pend;
    logic [7:0]               r_esc_val;
    logic [1:0]               r_esc_dig;
    logic [POSITION_WIDTH-1:0] r_line, r_col, r_tline, r_tcol;

    // result buffer
    t_res [MaxResults-1:0]    r_res;
    logic [2:0]               r_cnt;
    logic [1:0]               r_idx;
    logic [POSITION_WIDTH-1:0] r_bl, r_bc, r_btl, r_btc;

    t_mode      n_mode;
    logic [7:0] n_pend, n_esc_val;
    logic [1:0] n_esc_dig;
    logic       tok_start;
    t_res_set   set;
    logic       in_fire, out_fire, last_out;
    t_res       cur;

    slex_core u_core (
        .i_byte(i_in.payload[7:0]), .i_eoi(i_in.payload[8]),
        .i_mode(r_mode), .i_pend(r_pend), .i_esc_val(r_esc_val),
        .i_esc_dig(r_esc_dig), .o_mode(n_mode), .o_pend(n_pend),
        .o_esc_val(n_esc_val), .o_esc_dig(n_esc_dig),
        .o_tok_start(tok_start), .o_set(set)
    );

    assign cur      = r_res[r_idx];
    assign last_out = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign out_fire = o_out.valid && o_out.ready;
    // buffer empty, or the final buffered result leaves now
    assign i_in.ready = (r_cnt == 3'd0) || (out_fire && last_out);
    assign in_fire  = i_in.valid && i_in.ready;

    assign o_out.valid = r_cnt != 3'd0;
    // token-start results of this item use the current position
    assign o_out.payload = {cur.is_end, cur.ttype, cur.op, cur.data,
        cur.at_cur ? r_bl : r_btl, cur.at_cur ? r_bc : r_btc, last_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pend <= '0;
            r_esc_val <= '0;
            r_esc_dig <= '0;
            r_line <= PosOne;
            r_col <= PosOne;
            r_tline <= PosOne;
            r_tcol <= PosOne;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (in_fire) begin
                // a new transaction also retires the final buffered result
                r_res <= set.res;
                r_cnt <= set.count;
                r_idx <= '0;
                r_bl <= r_line;
                r_bc <= r_col;
                r_btl <= r_tline;
                r_btc <= r_tcol;
                r_mode <= n_mode;
                r_pend <= n_pend;
                r_esc_val <= n_esc_val;
                r_esc_dig <= n_esc_dig;
                if (i_in.payload[8]) begin
                    r_line <= PosOne;
                    r_col <= PosOne;
                    r_tline <= PosOne;
                    r_tcol <= PosOne;
                end else begin
                    if (tok_start) begin
                        r_tline <= r_line;
                        r_tcol <= r_col;
                    end
                    if (i_in.payload[7:0] == 8'h0a) begin
                        if (r_line != PosMax) r_line <= r_line + PosOne;
                        r_col <= PosOne;
                    end else if (r_col != PosMax) begin
                        r_col <= r_col + PosOne;
                    end
                end
            end else if (out_fire) begin
                if (last_out) r_cnt <= '0;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // no new item while results still wait
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0 && !out_fire) |-> !i_in.ready) else $error("accept while busy");
    // buffer never holds more than four results
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("result count overflow");
    // end of input brings the lexer back to idle
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.payload[8]) |=> r_mode == M_IDLE) else $error("no idle after end");
endmodule
`default_nettype wire
